>>> rtl/tccw_pkg.sv
// Shared types and constants for the text console cell writer.
// Depends on nothing; all other files but tccw_fifo use it by scoped names.
package tccw_pkg;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] SPACE_CODE   = 8'h20;
  localparam logic [7:0] RESET_COLOR  = 8'h0F;

  // Configuration port
  localparam int unsigned APB_AW = 3;
  localparam int unsigned APB_DW = 32;
  localparam logic        REG_TEXT_COLOR = 1'b0;  // register index, from paddr[2]

  typedef enum logic [1:0] {
    OP_PUT_CUR = 2'd0,
    OP_PUT_POS = 2'd1,
    OP_CLEAR   = 2'd2,
    OP_READ    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    BK_SWEEP,
    BK_RUN,
    BK_READ
  } bk_state_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] char_code;
    logic [6:0] col_pos;
    logic [4:0] row_pos;
  } in_item_t;

  typedef struct packed {
    logic [15:0] cell_value;
    logic [4:0]  cursor_row;
    logic [6:0]  cursor_col;
    logic        scrolled;
  } out_item_t;

  // Classified command passed from the front end to the back end
  typedef struct packed {
    op_e        op;
    logic [7:0] char_code;
    logic [6:0] col_pos;
    logic [4:0] row_pos;
    logic       on_screen;
    logic       newline;
  } cmd_t;

endpackage

>>> rtl/text_console_cell_writer.sv
// Text console cell writer: character-cell screen with cursor and scrolling.
// Depends on tccw_pkg, tccw_fifo, tccw_front and tccw_back.
//
// Items enter through push/full and results leave through empty/pop; each
// item gives exactly one result, in order. in_data_i carries the operation,
// character and position; out_data_o carries the cell read, the cursor after
// the operation and a scroll flag. The colour attribute register sits at
// APB address 0 and is written in the access phase of an APB write.
// A push is registered in the command queue and its result in the result
// queue before it shows on the queue head; a read also passes the registered
// memory read port, which holds the back end in BK_READ. Character writes and
// put-at-position run at one item per cycle while the result queue has room.
// A scroll blanks one row through the single memory write port, so the next
// item waits until that row is blanked; a clear rewrites every cell and holds
// the back end until all are done. After reset the memory is swept to
// white-on-black spaces, all ROWS*COLUMNS cells (2000 by default), during which
// pushed items queue but are not executed. A stalled receiver fills the result
// queue, then the command queue, then full rises.
module text_console_cell_writer #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  tccw_pkg::in_item_t                  in_data_i,
  output logic                                empty,
  input  logic                                pop,
  output tccw_pkg::out_item_t                 out_data_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tccw_pkg::APB_AW-1:0]         paddr,
  input  logic [tccw_pkg::APB_DW-1:0]         pwdata,
  output logic [tccw_pkg::APB_DW-1:0]         prdata,
  output logic                                pready
);

  logic [7:0]          text_color_q;
  tccw_pkg::cmd_t      front_cmd, back_cmd;
  logic                cmd_empty, cmd_pop;
  tccw_pkg::out_item_t back_res;
  logic                res_push, res_full;
  logic                reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == tccw_pkg::REG_TEXT_COLOR);
  assign prdata  = reg_sel ? {{(tccw_pkg::APB_DW - 8){1'b0}}, text_color_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_color_q <= tccw_pkg::RESET_COLOR;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      text_color_q <= pwdata[7:0];
    end
  end

  tccw_front #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_front (
    .in_data_i (in_data_i),
    .cmd_o     (front_cmd)
  );

  tccw_fifo #(.Width($bits(tccw_pkg::cmd_t)), .Depth(2)) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_cmd),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .data_o  (back_cmd),
    .empty_o (cmd_empty)
  );

  tccw_back #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (back_cmd),
    .cmd_valid_i  (!cmd_empty),
    .cmd_pop_o    (cmd_pop),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (back_res),
    .text_color_i (text_color_q)
  );

  tccw_fifo #(.Width($bits(tccw_pkg::out_item_t)), .Depth(2)) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (back_res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_data_o),
    .empty_o (empty)
  );

endmodule

>>> rtl/tccw_fifo.sv
// Small synchronous FIFO used for the command queue and the result queue.
// Depends on nothing.
module tccw_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned NW = $clog2(Depth + 1);

  logic [Width-1:0] store_q [Depth];
  logic [PW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [NW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == NW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = store_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      store_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

>>> rtl/tccw_front.sv
// Front end: decodes an incoming item and classifies it for the back end.
// Depends on tccw_pkg.
module tccw_front #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  tccw_pkg::in_item_t in_data_i,
  output tccw_pkg::cmd_t     cmd_o
);

  always_comb begin
    cmd_o.op        = tccw_pkg::op_e'(in_data_i.operation);
    cmd_o.char_code = in_data_i.char_code;
    cmd_o.col_pos   = in_data_i.col_pos;
    cmd_o.row_pos   = in_data_i.row_pos;
    cmd_o.on_screen = (32'(in_data_i.col_pos) < COLUMNS) &&
                      (32'(in_data_i.row_pos) < ROWS);
    cmd_o.newline   = (in_data_i.char_code == tccw_pkg::NEWLINE_CODE);
  end

endmodule

>>> rtl/tccw_back.sv
// Back end: cursor, circular row offset, screen memory and fill sweeper.
// Depends on tccw_pkg.
module tccw_back #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  tccw_pkg::cmd_t      cmd_i,
  input  logic                cmd_valid_i,
  output logic                cmd_pop_o,
  input  logic                res_full_i,
  output logic                res_push_o,
  output tccw_pkg::out_item_t res_o,
  input  logic [7:0]          text_color_i
);

  localparam int unsigned CELLS = COLUMNS * ROWS;
  localparam int unsigned AW    = $clog2(CELLS);
  localparam int unsigned RW    = $clog2(ROWS);
  localparam int unsigned CW    = $clog2(COLUMNS);

  tccw_pkg::bk_state_e state_q, state_d;
  logic [RW-1:0] cur_row_q, cur_row_d;
  logic [CW-1:0] cur_col_q, cur_col_d;
  logic [RW-1:0] top_q, top_d;          // physical row shown as logical row 0
  logic [AW-1:0] sweep_addr_q, sweep_addr_d;
  logic [AW-1:0] sweep_last_q, sweep_last_d;
  logic [7:0]    sweep_attr_q, sweep_attr_d;

  logic [15:0] mem_q [CELLS];
  logic [15:0] rdata_q;
  logic        mem_we;
  logic [AW-1:0] mem_waddr;
  logic [15:0]   mem_wdata;

  logic          use_cursor;
  logic [RW-1:0] lrow, prow;
  logic [CW-1:0] lcol;
  logic [RW:0]   row_sum;
  logic [AW-1:0] cell_addr, top_base;
  logic          scrolled;
  logic [15:0]   cell_out;

  // Logical to physical address through the row offset
  always_comb begin
    use_cursor = (cmd_i.op == tccw_pkg::OP_PUT_CUR);
    lrow       = use_cursor ? cur_row_q : RW'(cmd_i.row_pos);
    lcol       = use_cursor ? cur_col_q : CW'(cmd_i.col_pos);
    row_sum    = {1'b0, lrow} + {1'b0, top_q};
    prow       = (row_sum >= (RW+1)'(ROWS)) ? RW'(row_sum - (RW+1)'(ROWS)) : RW'(row_sum);
    cell_addr  = AW'(prow) * AW'(COLUMNS) + AW'(lcol);
    top_base   = AW'(top_q) * AW'(COLUMNS);
  end

  always_comb begin
    state_d      = state_q;
    cur_row_d    = cur_row_q;
    cur_col_d    = cur_col_q;
    top_d        = top_q;
    sweep_addr_d = sweep_addr_q;
    sweep_last_d = sweep_last_q;
    sweep_attr_d = sweep_attr_q;
    mem_we       = 1'b0;
    mem_waddr    = cell_addr;
    mem_wdata    = {text_color_i, cmd_i.char_code};
    cmd_pop_o    = 1'b0;
    res_push_o   = 1'b0;
    scrolled     = 1'b0;
    cell_out     = '0;
    case (state_q)
      tccw_pkg::BK_SWEEP: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_addr_q;
        mem_wdata = {sweep_attr_q, tccw_pkg::SPACE_CODE};
        if (sweep_addr_q == sweep_last_q) begin
          state_d = tccw_pkg::BK_RUN;
        end else begin
          sweep_addr_d = sweep_addr_q + 1'b1;
        end
      end
      tccw_pkg::BK_RUN: begin
        if (cmd_valid_i && !res_full_i) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.op)
            tccw_pkg::OP_PUT_CUR: begin
              res_push_o = 1'b1;
              mem_we     = !cmd_i.newline;
              if (cmd_i.newline || (cur_col_q == CW'(COLUMNS - 1))) begin
                cur_col_d = '0;
                if (cur_row_q == RW'(ROWS - 1)) begin
                  // Scroll: advance the offset and blank the old top row,
                  // which becomes the new bottom row
                  scrolled     = 1'b1;
                  top_d        = (top_q == RW'(ROWS - 1)) ? '0 : top_q + 1'b1;
                  sweep_addr_d = top_base;
                  sweep_last_d = top_base + AW'(COLUMNS - 1);
                  sweep_attr_d = text_color_i;
                  state_d      = tccw_pkg::BK_SWEEP;
                end else begin
                  cur_row_d = cur_row_q + 1'b1;
                end
              end else begin
                cur_col_d = cur_col_q + 1'b1;
              end
            end
            tccw_pkg::OP_PUT_POS: begin
              res_push_o = 1'b1;
              mem_we     = cmd_i.on_screen;
            end
            tccw_pkg::OP_CLEAR: begin
              res_push_o   = 1'b1;
              cur_row_d    = '0;
              cur_col_d    = '0;
              top_d        = '0;
              sweep_addr_d = '0;
              sweep_last_d = AW'(CELLS - 1);
              sweep_attr_d = text_color_i;
              state_d      = tccw_pkg::BK_SWEEP;
            end
            tccw_pkg::OP_READ: begin
              if (cmd_i.on_screen) begin
                state_d = tccw_pkg::BK_READ;
              end else begin
                res_push_o = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      tccw_pkg::BK_READ: begin
        // room was checked when the read was taken; nothing pushed since
        res_push_o = 1'b1;
        cell_out   = rdata_q;
        state_d    = tccw_pkg::BK_RUN;
      end
      default: state_d = tccw_pkg::BK_RUN;
    endcase

    res_o.cell_value = cell_out;
    res_o.cursor_row = 5'(cur_row_d);
    res_o.cursor_col = 7'(cur_col_d);
    res_o.scrolled   = scrolled;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= tccw_pkg::BK_SWEEP;
      cur_row_q    <= '0;
      cur_col_q    <= '0;
      top_q        <= '0;
      sweep_addr_q <= '0;
      sweep_last_q <= AW'(CELLS - 1);
      sweep_attr_q <= tccw_pkg::RESET_COLOR;
    end else begin
      state_q      <= state_d;
      cur_row_q    <= cur_row_d;
      cur_col_q    <= cur_col_d;
      top_q        <= top_d;
      sweep_addr_q <= sweep_addr_d;
      sweep_last_q <= sweep_last_d;
      sweep_attr_q <= sweep_attr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[cell_addr];
  end

endmodule

>>> rtl/tccw_checker.sv
// Port-level checks for the text console cell writer, bound to the top level.
// Depends on tccw_pkg and text_console_cell_writer.
module tccw_checker #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        empty,
  input logic                        pop,
  input tccw_pkg::out_item_t         out_data_o,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic                        pready,
  input logic [tccw_pkg::APB_AW-1:0] paddr,
  input logic [tccw_pkg::APB_DW-1:0] pwdata,
  input logic [tccw_pkg::APB_DW-1:0] prdata
);

  // A waiting result holds until its transfer
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(out_data_o))
    else $error("result changed before its transfer");

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (32'(out_data_o.cursor_col) < COLUMNS) &&
               (32'(out_data_o.cursor_row) < ROWS))
    else $error("cursor off screen");

  a_scroll_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && out_data_o.scrolled |->
      (32'(out_data_o.cursor_row) == ROWS - 1) && (out_data_o.cursor_col == '0))
    else $error("scroll left cursor away from start of bottom row");

  a_color_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && !paddr[2]) ##1 (psel && !paddr[2]) |->
      prdata[7:0] == $past(pwdata[7:0]))
    else $error("colour register read back wrong");

endmodule

bind text_console_cell_writer tccw_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_tccw_checker (.*);
